>>> rtl/core/npc_pkg.sv
// ----------------------------------------------------------------------------
// npc_pkg
// Shared codes, field widths and parameter defaults of the nearest
// prototype classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package npc_pkg;

   // Field widths of the request and response items
   localparam int CMD_W          = 2;
   localparam int SAMPLE_FIELD_W = 12;
   localparam int MAT_FIELD_W    = 2;
   localparam int STATUS_W       = 2;

   // Widest stored sample; incoming samples are zero-extended to this first
   localparam int SAMPLE_EXT_W   = 16;

   // Stream data widths, padded to whole bytes
   localparam int REQ_TDATA_W    = 16;
   localparam int RSP_TDATA_W    = 8;

   // Parameter defaults
   localparam int DEF_MAX_MATERIALS = 4;
   localparam int DEF_SAMPLE_BITS   = 12;

   // Request commands; code 3 is unused and ignored
   typedef enum logic [CMD_W-1:0] {
      CMD_CLASSIFY = 2'd0,
      CMD_LEARN    = 2'd1,
      CMD_CLEAR    = 2'd2
   } cmd_type;

   // Response status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

endpackage

`default_nettype wire

>>> rtl/core/npc_cell.sv
// ----------------------------------------------------------------------------
// npc_cell
// One link of the prototype chain: stores one learned sample and passes the
// running nearest match of a classify search on to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module npc_cell #(
   parameter int INDEX       = 0,
   parameter int SAMPLE_BITS = 12,
   parameter int IDX_W       = 2,
   parameter int CNT_W       = 3
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // learn write into this cell
   input  wire logic                   wr_en,
   input  wire logic [SAMPLE_BITS-1:0] wr_data,
   // number of learned entries
   input  wire logic [CNT_W-1:0]       count,
   // search token from the previous cell
   input  wire logic                   in_valid,
   input  wire logic [SAMPLE_BITS-1:0] in_sample,
   input  wire logic [SAMPLE_BITS-1:0] in_dist,
   input  wire logic [IDX_W-1:0]       in_idx,
   // search token to the next cell
   output logic                        out_valid,
   output logic [SAMPLE_BITS-1:0]      out_sample,
   output logic [SAMPLE_BITS-1:0]      out_dist,
   output logic [IDX_W-1:0]            out_idx
);

   logic [SAMPLE_BITS-1:0] proto_ff;
   logic [SAMPLE_BITS-1:0] diff;
   logic                   active;
   logic                   take;

   logic                   valid_ff;
   logic [SAMPLE_BITS-1:0] sample_ff;
   logic [SAMPLE_BITS-1:0] dist_ff, dist_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;

   // Store the learned sample
   always_ff @(posedge clock) begin
      if (wr_en) begin
         proto_ff <= wr_data;
      end
   end

   // Distance to this prototype; the first cell always takes the lead,
   // later cells only on a strictly smaller distance so ties keep the lower index
   always_comb begin
      diff   = (in_sample >= proto_ff) ? (in_sample - proto_ff) : (proto_ff - in_sample);
      active = (CNT_W'(INDEX) < count);
      take   = active && ((INDEX == 0) || (diff < in_dist));
      dist_in = take ? diff : in_dist;
      idx_in  = take ? IDX_W'(INDEX) : in_idx;
   end

   // Advance the token
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= in_sample;
      dist_ff   <= dist_in;
      idx_ff    <= idx_in;
   end

   assign out_valid  = valid_ff;
   assign out_sample = sample_ff;
   assign out_dist   = dist_ff;
   assign out_idx    = idx_ff;

   // The best match leaving this cell never points past it
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (idx_ff <= IDX_W'(INDEX)))
      else $error("npc_cell: best index beyond cell position");

   // A search token only runs while something is learned
   a_token_learned: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (count != '0))
      else $error("npc_cell: search token with an empty table");

   // A cell past the learned count hands the token on unchanged
   a_pass_through: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && (count <= CNT_W'(INDEX))) |->
         ((idx_ff == $past(in_idx)) && (dist_ff == $past(in_dist))))
      else $error("npc_cell: unused cell changed the best match");

endmodule

`default_nettype wire

>>> rtl/core/nearest_prototype_classifier.sv
// ----------------------------------------------------------------------------
// nearest_prototype_classifier
// Learns up to MAX_MATERIALS sensor readings and reports the index of the
// stored reading nearest to a sample.
// ----------------------------------------------------------------------------
// One request is handled at a time and every request gives one response.
// Learn, clear and unused commands pass from idle straight to the done state;
// a classify first walks a search token down the row of prototype cells at
// one cell per clock. The response sits in an output register, so the next
// request is taken while it waits for rsp_tready.
// Learning into a full table returns status 1 and index 0; classifying with
// nothing learned returns status 2 and index 0. Ties go to the lower index.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_prototype_classifier
#(
   parameter int MAX_MATERIALS = npc_pkg::DEF_MAX_MATERIALS,
   parameter int SAMPLE_BITS   = npc_pkg::DEF_SAMPLE_BITS
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request: [1:0] cmd, [13:2] sample, [15:14] zero
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [npc_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // response: [1:0] material_index, [3:2] status, [7:4] zero
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [npc_pkg::RSP_TDATA_W-1:0]       rsp_tdata
);

   import npc_pkg::*;

   localparam int IDX_W = $clog2(MAX_MATERIALS);
   localparam int CNT_W = $clog2(MAX_MATERIALS + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_DONE
   } state_type;

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [IDX_W-1:0]       res_idx_ff, res_idx_in;
   status_type             res_status_ff, res_status_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]       rsp_idx_ff, rsp_idx_in;
   status_type             rsp_status_ff, rsp_status_in;

   logic                   req_accept;
   cmd_type                req_cmd;
   logic [SAMPLE_FIELD_W-1:0] req_sample;
   logic [SAMPLE_EXT_W-1:0]   sample_ext;
   logic [SAMPLE_BITS-1:0]    sample;
   logic                   learn_go;
   logic [IDX_W+MAT_FIELD_W-1:0] idx_ext;

   // search chain, position i feeds cell i
   logic [MAX_MATERIALS:0] tok_valid;
   logic [SAMPLE_BITS-1:0] tok_sample [MAX_MATERIALS+1];
   logic [SAMPLE_BITS-1:0] tok_dist   [MAX_MATERIALS+1];
   logic [IDX_W-1:0]       tok_idx    [MAX_MATERIALS+1];

   // Unpack the request
   assign req_cmd    = cmd_type'(req_tdata[CMD_W-1:0]);
   assign req_sample = req_tdata[CMD_W +: SAMPLE_FIELD_W];
   assign sample_ext = SAMPLE_EXT_W'(req_sample);
   assign sample     = sample_ext[SAMPLE_BITS-1:0];

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign learn_go   = req_accept && (req_cmd == CMD_LEARN) &&
                       (count_ff < CNT_W'(MAX_MATERIALS));

   // Inject a search token into the first cell
   assign tok_valid[0]  = req_accept && (req_cmd == CMD_CLASSIFY) && (count_ff != '0);
   assign tok_sample[0] = sample;
   assign tok_dist[0]   = '0;
   assign tok_idx[0]    = '0;

   // Row of prototype cells
   for (genvar i = 0; i < MAX_MATERIALS; i++) begin : g_cell
      npc_cell #(
         .INDEX       (i),
         .SAMPLE_BITS (SAMPLE_BITS),
         .IDX_W       (IDX_W),
         .CNT_W       (CNT_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .wr_en      (learn_go && (count_ff == CNT_W'(i))),
         .wr_data    (sample),
         .count      (count_ff),
         .in_valid   (tok_valid[i]),
         .in_sample  (tok_sample[i]),
         .in_dist    (tok_dist[i]),
         .in_idx     (tok_idx[i]),
         .out_valid  (tok_valid[i+1]),
         .out_sample (tok_sample[i+1]),
         .out_dist   (tok_dist[i+1]),
         .out_idx    (tok_idx[i+1])
      );
   end

   // Sequence one request, then hand its result to the output register
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      res_idx_in    = res_idx_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_idx_in    = rsp_idx_ff;
      rsp_status_in = rsp_status_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               res_idx_in    = '0;
               res_status_in = ST_OK;
               state_in      = S_DONE;
               case (req_cmd)
                  CMD_CLASSIFY: begin
                     if (count_ff == '0) begin
                        res_status_in = ST_EMPTY;
                     end else begin
                        state_in = S_SEARCH;
                     end
                  end
                  CMD_LEARN: begin
                     if (learn_go) begin
                        res_idx_in = count_ff[IDX_W-1:0];
                        count_in   = count_ff + CNT_W'(1);
                     end else begin
                        res_status_in = ST_FULL;
                     end
                  end
                  CMD_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                     res_status_in = ST_OK;
                  end
               endcase
            end
         end
         S_SEARCH: begin
            if (tok_valid[MAX_MATERIALS]) begin
               res_idx_in    = tok_idx[MAX_MATERIALS];
               res_status_in = ST_OK;
               state_in      = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_idx_in    = res_idx_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      res_idx_ff    <= res_idx_in;
      res_status_ff <= res_status_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Pack the response
   assign idx_ext    = (IDX_W + MAT_FIELD_W)'(rsp_idx_ff);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - MAT_FIELD_W - STATUS_W){1'b0}},
                        rsp_status_ff, idx_ext[MAT_FIELD_W-1:0]};

   // At most one search token is in the chain
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $countones(tok_valid[MAX_MATERIALS:1]) <= 1)
      else $error("npc: more than one search token in flight");

   // A new request never meets a token still in the chain
   a_chain_idle: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> (tok_valid[MAX_MATERIALS:1] == '0))
      else $error("npc: request taken during a search");

   // The learned count stays within the table
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_MATERIALS))
      else $error("npc: learned count beyond table depth");

   // A dropped learn reports index zero
   a_full_idx: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == ST_FULL)) |-> (rsp_idx_ff == '0))
      else $error("npc: full-table response with nonzero index");

endmodule

`default_nettype wire
